// ===== rtl/rsb_pkg.sv =====
package rsb_pkg;

  // Store geometry
  localparam int DEPTH  = 1024;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Field widths
  localparam int KIND_W = 2;
  localparam int DATA_W = 64;
  localparam int RND_W  = 32;
  localparam int CFG_W  = 11;
  localparam int MEM_W  = DATA_W + 1;

  localparam logic [CFG_W-1:0] SIZE_RST = CFG_W'(1024);

  // Item kinds
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_PUSH = 2'd0;
  localparam kind_t KIND_END  = 2'd1;
  localparam kind_t KIND_DRAW = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch_in;    // capture the accepted transaction
    logic rem_start;   // start the remainder unit
    logic rem_head;    // remainder of head by size, else random by fill
    logic head_load;   // head takes the remainder result
    logic clamp_fill;  // clamp fill count to the size
    logic set_ended;   // mark input as finished
    logic push_write;  // write element at tail, bump fill count
    logic pick_calc;   // form the picked slot index
    logic rd_head;     // memory read address: head, else picked slot
    logic cap_res;     // capture picked element from memory
    logic wr_pick;     // move head element to picked slot, advance head
    logic out_load;    // load the output register
    logic out_end;     // output register carries an end result
  } rsb_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  ended;
    logic  head_ge;
    logic  fill_full;
    logic  fill_zero;
    logic  push_last;
    logic  rem_done;
    logic  out_free;
  } rsb_sts_t;

endpackage

// ===== rtl/rsb_ram.sv =====
module rsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rsb_rem.sv =====
module rsb_rem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rsb_pkg::RND_W-1:0] dividend,
  input  logic [rsb_pkg::CNT_W-1:0] divisor,
  output logic [rsb_pkg::CNT_W-1:0] rem,
  output logic                      done
);

  localparam int STEP_W = $clog2(rsb_pkg::RND_W + 1);

  logic [STEP_W-1:0]         cnt_r,  cnt_nxt;
  logic                      done_r, done_nxt;
  logic [rsb_pkg::RND_W-1:0] dvd_r,  dvd_nxt;
  logic [rsb_pkg::CNT_W-1:0] dvs_r,  dvs_nxt;
  logic [rsb_pkg::CNT_W-1:0] part_r, part_nxt;
  logic [rsb_pkg::CNT_W:0]   trial;

  // One restoring step per cycle, most significant dividend bit first
  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    part_nxt = part_r;
    trial    = {part_r, dvd_r[rsb_pkg::RND_W-1]};
    if (start) begin
      cnt_nxt  = STEP_W'(rsb_pkg::RND_W);
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      part_nxt = '0;
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, dvs_r}) begin
        part_nxt = rsb_pkg::CNT_W'(trial - {1'b0, dvs_r});
      end else begin
        part_nxt = trial[rsb_pkg::CNT_W-1:0];
      end
      dvd_nxt = {dvd_r[rsb_pkg::RND_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      done_nxt = (cnt_r == STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
    part_r <= part_nxt;
  end

  assign rem  = part_r;
  assign done = done_r;

endmodule

// ===== rtl/rsb_datapath.sv =====
module rsb_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rsb_pkg::rsb_cmd_t          cmd,
  output rsb_pkg::rsb_sts_t          sts,
  input  logic                       cfg_we,
  input  logic [rsb_pkg::CFG_W-1:0]  cfg_wdata,
  input  rsb_pkg::kind_t             in_kind,
  input  logic [rsb_pkg::DATA_W-1:0] in_data,
  input  logic                       in_error,
  input  logic [rsb_pkg::RND_W-1:0]  in_random_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rsb_pkg::DATA_W-1:0] out_data,
  output logic                       out_error,
  output logic                       out_end
);

  localparam int IDX_W = rsb_pkg::IDX_W;
  localparam int CNT_W = rsb_pkg::CNT_W;

  logic [rsb_pkg::CFG_W-1:0]  size_cfg_r;
  logic [CNT_W-1:0]           size_c;
  logic [IDX_W-1:0]           head_r;
  logic [CNT_W-1:0]           fill_r;
  logic [CNT_W-1:0]           fill_c;
  logic                       ended_r;
  rsb_pkg::kind_t             kind_r;
  logic [rsb_pkg::DATA_W-1:0] data_r;
  logic                       err_r;
  logic [rsb_pkg::RND_W-1:0]  rnd_r;
  logic [IDX_W-1:0]           pick_r;
  logic [rsb_pkg::MEM_W-1:0]  res_r;
  logic                       out_valid_r;
  logic [rsb_pkg::DATA_W-1:0] out_data_r;
  logic                       out_error_r;
  logic                       out_end_r;

  logic [rsb_pkg::RND_W-1:0]  rem_dvd;
  logic [CNT_W-1:0]           rem_dvs;
  logic [CNT_W-1:0]           rem_q;
  logic                       rem_done;
  logic [CNT_W:0]             tail_sum;
  logic [IDX_W-1:0]           tail;
  logic [CNT_W:0]             pick_sum;
  logic [IDX_W-1:0]           pick_c;
  logic [CNT_W-1:0]           head_inc;
  logic                       mem_we;
  logic [IDX_W-1:0]           mem_waddr;
  logic [rsb_pkg::MEM_W-1:0]  mem_wdata;
  logic [IDX_W-1:0]           mem_raddr;
  logic [rsb_pkg::MEM_W-1:0]  mem_rdata;

  // Effective size: zero acts as one, oversize acts as the full store
  always_comb begin
    if (size_cfg_r == '0) begin
      size_c = CNT_W'(1);
    end else if (32'(size_cfg_r) > 32'(rsb_pkg::DEPTH)) begin
      size_c = CNT_W'(rsb_pkg::DEPTH);
    end else begin
      size_c = CNT_W'(size_cfg_r);
    end
  end

  assign fill_c = (fill_r > size_c) ? size_c : fill_r;

  // Circular index arithmetic; both operands stay below the size
  assign tail_sum = {1'b0, CNT_W'(head_r)} + {1'b0, fill_r};
  assign tail     = (tail_sum >= {1'b0, size_c}) ?
                    IDX_W'(tail_sum - {1'b0, size_c}) : IDX_W'(tail_sum);
  assign pick_sum = {1'b0, CNT_W'(head_r)} + {1'b0, rem_q};
  assign pick_c   = (pick_sum >= {1'b0, size_c}) ?
                    IDX_W'(pick_sum - {1'b0, size_c}) : IDX_W'(pick_sum);
  assign head_inc = CNT_W'(head_r) + 1'b1;

  // Remainder operands
  assign rem_dvd = cmd.rem_head ? rsb_pkg::RND_W'(head_r) : rnd_r;
  assign rem_dvs = cmd.rem_head ? size_c : fill_r;

  rsb_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.rem_start),
    .dividend (rem_dvd),
    .divisor  (rem_dvs),
    .rem      (rem_q),
    .done     (rem_done)
  );

  // Memory ports
  assign mem_we    = cmd.push_write | cmd.wr_pick;
  assign mem_waddr = cmd.wr_pick ? pick_r : tail;
  assign mem_wdata = cmd.wr_pick ? mem_rdata : {err_r, data_r};
  assign mem_raddr = cmd.rd_head ? head_r : pick_r;

  rsb_ram #(
    .WIDTH (rsb_pkg::MEM_W),
    .DEPTH (rsb_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Control state: size register, head, fill count, end mark, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_cfg_r  <= rsb_pkg::SIZE_RST;
      head_r      <= '0;
      fill_r      <= '0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_cfg_r <= cfg_wdata;
      end
      if (cmd.head_load) begin
        head_r <= rem_q[IDX_W-1:0];
      end else if (cmd.wr_pick) begin
        head_r <= (head_inc == size_c) ? '0 : head_inc[IDX_W-1:0];
      end
      if (cmd.clamp_fill) begin
        fill_r <= fill_c;
      end else if (cmd.push_write) begin
        fill_r <= fill_r + 1'b1;
      end else if (cmd.wr_pick) begin
        fill_r <= fill_r - 1'b1;
      end
      if (cmd.set_ended) begin
        ended_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r <= in_kind;
      data_r <= in_data;
      err_r  <= in_error;
      rnd_r  <= in_random_word;
    end
    if (cmd.pick_calc) begin
      pick_r <= pick_c;
    end
    if (cmd.cap_res) begin
      res_r <= mem_rdata;
    end
    if (cmd.out_load) begin
      out_data_r  <= cmd.out_end ? '0 : res_r[rsb_pkg::DATA_W-1:0];
      out_error_r <= cmd.out_end ? 1'b0 : res_r[rsb_pkg::DATA_W];
      out_end_r   <= cmd.out_end;
    end
  end

  // Status to controller
  assign sts.kind      = kind_r;
  assign sts.ended     = ended_r;
  assign sts.head_ge   = (CNT_W'(head_r) >= size_c);
  assign sts.fill_full = (fill_c == size_c);
  assign sts.fill_zero = (fill_c == '0);
  assign sts.push_last = ((fill_r + 1'b1) == size_c);
  assign sts.rem_done  = rem_done;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_error = out_error_r;
  assign out_end   = out_end_r;

endmodule

// ===== rtl/rsb_ctrl.sv =====
module rsb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rsb_pkg::rsb_sts_t sts,
  output rsb_pkg::rsb_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_NORM,
    ST_DISPATCH,
    ST_PUSH,
    ST_EMIT,
    ST_REM,
    ST_PICK,
    ST_RD_PICK,
    ST_RD_HEAD,
    ST_WR_PICK,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   end_res_r, end_res_nxt;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    end_res_nxt = end_res_r;
    cmd         = '0;
    cmd.out_end = end_res_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // Reduce head into range after a size change
        if (sts.head_ge) begin
          cmd.rem_start = 1'b1;
          cmd.rem_head  = 1'b1;
          state_nxt     = ST_NORM;
        end else begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_NORM: begin
        if (sts.rem_done) begin
          cmd.head_load = 1'b1;
          state_nxt     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.clamp_fill = 1'b1;
        state_nxt      = ST_IDLE;
        case (sts.kind)
          rsb_pkg::KIND_PUSH: begin
            if (!sts.ended) begin
              state_nxt = sts.fill_full ? ST_EMIT : ST_PUSH;
            end
          end
          rsb_pkg::KIND_END: begin
            cmd.set_ended = 1'b1;
          end
          rsb_pkg::KIND_DRAW: begin
            if (sts.ended) begin
              if (sts.fill_zero) begin
                end_res_nxt = 1'b1;
                state_nxt   = ST_RESULT;
              end else begin
                state_nxt = ST_EMIT;
              end
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_PUSH: begin
        cmd.push_write = 1'b1;
        state_nxt      = sts.push_last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        cmd.rem_start = 1'b1;
        state_nxt     = ST_REM;
      end
      ST_REM: begin
        if (sts.rem_done) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        cmd.pick_calc = 1'b1;
        state_nxt     = ST_RD_PICK;
      end
      ST_RD_PICK: begin
        state_nxt = ST_RD_HEAD;
      end
      ST_RD_HEAD: begin
        cmd.rd_head = 1'b1;
        cmd.cap_res = 1'b1;
        state_nxt   = ST_WR_PICK;
      end
      ST_WR_PICK: begin
        cmd.wr_pick = 1'b1;
        state_nxt   = ST_RESULT;
      end
      ST_RESULT: begin
        // Hold until the output register frees up
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          end_res_nxt  = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      end_res_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      end_res_r <= end_res_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

// ===== rtl/random_shuffle_buffer_core.sv =====
// Random shuffle buffer: stores pushed elements in a circular store and hands
// them out in random order.
// Input channel (in_valid/in_ready): in_kind selects push, end of input or
// draw; in_random_word picks the slot to emit. Output channel
// (out_valid/out_ready): one element, or an end marker (out_end) once the
// input has ended and the store is empty.
// cfg_we/cfg_wdata set the number of slots in use; write only while idle.
// One transaction at a time. A push that fills the store or arrives when it
// is full, and a draw on an ended store that is not empty, emit one element:
// the emit runs the 32-step remainder of the random word by the fill count,
// reads the picked slot, then the head, and moves the head element into the
// picked slot. The result shows in the cycle that can take the next item.
// After a size change that leaves the head out of range, the next item first
// reduces the head with the same remainder unit.
// Reset clears head, fill count and end mark; the store is not cleared.
// The output register lets the next transaction be accepted while a result
// waits; if the receiver stalls, a following result holds in the block and
// no new input is taken until the output register frees up.
module random_shuffle_buffer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [rsb_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rsb_pkg::kind_t             in_kind,
  input  logic [rsb_pkg::DATA_W-1:0] in_data,
  input  logic                       in_error,
  input  logic [rsb_pkg::RND_W-1:0]  in_random_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rsb_pkg::DATA_W-1:0] out_data,
  output logic                       out_error,
  output logic                       out_end
);

  rsb_pkg::rsb_cmd_t cmd;
  rsb_pkg::rsb_sts_t sts;

  rsb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rsb_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_kind        (in_kind),
    .in_data        (in_data),
    .in_error       (in_error),
    .in_random_word (in_random_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .out_error      (out_error),
    .out_end        (out_end)
  );

endmodule

// ===== rtl/rsb_checker.sv =====
module rsb_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rsb_pkg::DATA_W-1:0] out_data,
  input logic                       out_error,
  input logic                       out_end
);

  // Reset leaves the block ready with nothing to deliver
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

  // An end result carries no element
  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end) |-> (out_data == '0 && !out_error))
    else $error("end result carries data");

  // One transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while busy");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_data) && $stable(out_error) && $stable(out_end)))
    else $error("stalled result changed");

endmodule

bind random_shuffle_buffer_core rsb_checker u_rsb_checker (.*);
